>>> rtl/swlf_pkg.sv
// ----------------------------------------------------------------------------
// swlf_pkg
// Shared constants and types of the sliding window line fit block.
// ----------------------------------------------------------------------------
package swlf_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int OUT_BITS        = 48;
	localparam int FRAC_BITS       = 16;
	localparam int SPAN_BITS       = 8;

	localparam logic [SPAN_BITS-1:0] SPAN_RESET = 8'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MUL,
		ST_NUM,
		ST_DIV_A,
		ST_DIV_B,
		ST_EMIT
	} swlf_state_t;

endpackage

>>> rtl/sliding_window_line_fit.sv
// ----------------------------------------------------------------------------
// sliding_window_line_fit
// Least-squares line over the last window_span+1 samples, Q31.16 results.
// ----------------------------------------------------------------------------
// One signed sample enters per input word; the last window_span+1 samples sit
// in a single-port ring memory next to a running sum and an index-weighted
// sum. While the window fills, a word gives no result. Once it is full, each
// word gives one output word holding intercept (low 48 bits) and slope (high
// 48 bits), with t = 0 at the oldest sample. The time per word is set by the
// bit-serial divider, shared in turn by the two coefficients; with window_span
// 0 the slope division is skipped. An output word that is not taken holds
// back the next result, and a new word is taken only once the last is done.
// tuser high drops the history before the sample is taken, and so does any
// write of window_span.
// ----------------------------------------------------------------------------
module sliding_window_line_fit
	import swlf_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [SPAN_BITS-1:0]                   cfg_wdata,   // window_span
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,     // sample
	input  logic                                   s_tuser,     // new_series
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [2*OUT_BITS-1:0]                  m_tdata      // intercept, slope
);

	localparam int AW   = $clog2(MAX_WINDOW);
	localparam int WS   = SAMPLE_BITS + AW + 1;
	localparam int WW   = SAMPLE_BITS + 2 * AW + 2;
	localparam int PAW  = WS + AW + 3;
	localparam int NW   = WW + 6;
	localparam int DENW = 3 * AW + 3;

	swlf_state_t state_q, state_d;

	logic [SPAN_BITS-1:0]          window_span_q;
	logic [AW-1:0]                 span;
	logic [AW:0]                   n;
	logic [AW:0]                   n_m1;
	logic [AW:0]                   n_p1;
	logic [AW+1:0]                 two_n_m1;

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic [AW-1:0]                 wp_q;
	logic [AW:0]                   fill_q;
	logic signed [WS-1:0]          sum_q;
	logic signed [WW-1:0]          wsum_q;

	logic signed [PAW-1:0]         p_a_q;
	logic signed [PAW-1:0]         p_b_q;
	logic [DENW-1:0]               den_a_q;
	logic [DENW-1:0]               den_b_q;
	logic [OUT_BITS-1:0]           intercept_q;
	logic [OUT_BITS-1:0]           slope_q;
	logic                          out_valid_q;
	logic [2*OUT_BITS-1:0]         out_data_q;

	logic                          accept;
	logic                          clear;
	logic                          full_now;
	logic                          full_next;
	logic [AW:0]                   wp_ext;
	logic [AW:0]                   old_diff;
	logic [AW-1:0]                 old_addr;
	logic [AW:0]                   upd_k;
	logic signed [AW+SAMPLE_BITS+1:0] upd_prod;
	logic signed [WS-1:0]          rest;
	logic signed [PAW-1:0]         pa_prod;
	logic signed [PAW-1:0]         pb_prod;
	logic [DENW-1:0]               den_a_prod;
	logic [DENW-1:0]               den_b_prod;
	logic signed [NW-1:0]          a_num;
	logic signed [NW-1:0]          b_half;
	logic signed [NW-1:0]          b_num;
	logic                          out_load;

	logic                          div_start;
	logic signed [NW-1:0]          div_num;
	logic [DENW-1:0]               div_den;
	logic                          div_done;
	logic [OUT_BITS-1:0]           div_quo;

	// window geometry
	always_comb begin
		if (int'(window_span_q) > MAX_WINDOW - 1) begin
			span = AW'(MAX_WINDOW - 1);
		end else begin
			span = AW'(window_span_q);
		end
	end

	assign n        = {1'b0, span} + (AW + 1)'(1);
	assign n_m1     = {1'b0, span};
	assign n_p1     = n + (AW + 1)'(1);
	assign two_n_m1 = {n, 1'b0} - (AW + 2)'(1);

	assign accept    = s_tvalid && s_tready;
	assign clear     = cfg_we || (accept && s_tuser);
	assign full_now  = fill_q >= n;
	assign full_next = fill_q >= n_m1;

	// oldest entry of the window
	assign wp_ext = {1'b0, wp_q};
	always_comb begin
		if (wp_ext >= n) begin
			old_diff = wp_ext - n;
		end else begin
			old_diff = wp_ext + (AW + 1)'(MAX_WINDOW) - n;
		end
	end
	assign old_addr = old_diff[AW-1:0];

	assign upd_k    = full_now ? n_m1 : fill_q;
	assign upd_prod = $signed({1'b0, upd_k}) * y_q;
	assign rest     = sum_q - WS'(rd_q);

	assign pa_prod    = $signed({1'b0, two_n_m1}) * sum_q;
	assign pb_prod    = $signed({1'b0, n_m1}) * sum_q;
	assign den_a_prod = DENW'(n) * DENW'(n_p1);
	assign den_b_prod = den_a_q * DENW'(n_m1);

	assign a_num  = (NW'(p_a_q) <<< 1) - ((NW'(wsum_q) <<< 2) + (NW'(wsum_q) <<< 1));
	assign b_half = (NW'(wsum_q) <<< 1) - NW'(p_b_q);
	assign b_num  = (b_half <<< 2) + (b_half <<< 1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = full_next ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				state_d = ST_NUM;
			end
			ST_NUM: begin
				state_d = ST_DIV_A;
			end
			ST_DIV_A: begin
				if (div_done) state_d = (span == '0) ? ST_EMIT : ST_DIV_B;
			end
			ST_DIV_B: begin
				if (div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		div_num   = b_num;
		div_den   = den_b_q;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_NUM: begin
				div_start = 1'b1;
				div_num   = a_num;
				div_den   = den_a_q;
			end
			ST_DIV_A: begin
				div_start = div_done && (span != '0);
			end
			ST_EMIT: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_span_q <= SPAN_RESET;
		end else if (cfg_we) begin
			window_span_q <= cfg_wdata;
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= ring[old_addr];
		end
		if (state_q == ST_UPDATE) begin
			ring[wp_q] <= y_q;
		end
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			wsum_q <= '0;
		end else if (clear) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			wsum_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (full_now) begin
				wsum_q <= wsum_q - WW'(rest) + WW'(upd_prod);
				sum_q  <= rest + WS'(y_q);
			end else begin
				wsum_q <= wsum_q + WW'(upd_prod);
				sum_q  <= sum_q + WS'(y_q);
				fill_q <= fill_q + (AW + 1)'(1);
			end
			if (wp_q == AW'(MAX_WINDOW - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			y_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_MUL) begin
			p_a_q   <= pa_prod;
			den_a_q <= den_a_prod;
		end
		if (state_q == ST_NUM) begin
			p_b_q   <= pb_prod;
			den_b_q <= den_b_prod;
		end
		if (state_q == ST_DIV_A && div_done) begin
			intercept_q <= div_quo;
			slope_q     <= '0;
		end
		if (state_q == ST_DIV_B && div_done) begin
			slope_q <= div_quo;
		end
		if (out_load) begin
			out_data_q <= {slope_q, intercept_q};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	swlf_div #(
		.NUM_BITS (NW),
		.DEN_BITS (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> rtl/swlf_div.sv
// ----------------------------------------------------------------------------
// swlf_div
// Radix-2 restoring divider: round(num * 2^16 / den), ties away from zero,
// saturated to signed Q31.16. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module swlf_div
	import swlf_pkg::*;
#(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 27
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic        [DEN_BITS-1:0] den,
	output logic                       done,
	output logic        [OUT_BITS-1:0] quo
);

	localparam int DVW  = NUM_BITS + FRAC_BITS + 2;
	localparam int CNTW = $clog2(DVW + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNTW-1:0]     cnt_q;
	logic [DVW-1:0]      dividend_q;
	logic [DEN_BITS:0]   dv_q;
	logic [DEN_BITS:0]   rem_q;
	logic [OUT_BITS-1:0] q_q;
	logic                ovf_q;
	logic                neg_q;

	logic [NUM_BITS-1:0] mag;
	logic [DEN_BITS+1:0] rem_sh;
	logic                qbit;
	logic [DEN_BITS+1:0] rem_sub;
	logic                big;

	assign mag     = (num < 0) ? NUM_BITS'(-num) : NUM_BITS'(num);
	assign rem_sh  = {rem_q, dividend_q[DVW-1]};
	assign qbit    = rem_sh >= {1'b0, dv_q};
	assign rem_sub = rem_sh - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q      <= num < 0;
			dividend_q <= DVW'({mag, {(FRAC_BITS + 1){1'b0}}}) + DVW'(den);
			dv_q       <= {den, 1'b0};
			rem_q      <= '0;
			q_q        <= '0;
			ovf_q      <= 1'b0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[DVW-2:0], 1'b0};
			rem_q      <= qbit ? rem_sub[DEN_BITS:0] : rem_sh[DEN_BITS:0];
			q_q        <= {q_q[OUT_BITS-2:0], qbit};
			ovf_q      <= ovf_q | q_q[OUT_BITS-1];
		end
	end

	// saturate at 2^47: clamp positive to max, negative to min
	assign big = ovf_q | q_q[OUT_BITS-1];

	always_comb begin
		if (neg_q) begin
			quo = big ? {1'b1, {(OUT_BITS - 1){1'b0}}} : -q_q;
		end else begin
			quo = big ? {1'b0, {(OUT_BITS - 1){1'b1}}} : q_q;
		end
	end

	assign done = done_q;

endmodule

>>> tb/sv/sliding_window_line_fit_test.sv
// ----------------------------------------------------------------------------
// sliding_window_line_fit_test
// Self-checking bench for the sliding window least-squares line fit.
// ----------------------------------------------------------------------------
// Sample words are queued phase by phase and sent in bursts with random gaps.
// The receiver stalls on a changing pattern. Every accepted sample updates a
// local model of the ring, the running sums and the window fill. That model
// yields the expected intercept and slope in Q31.16. Every output word is
// checked against the oldest expected fit. Between phases the bench lets the
// block drain before it writes window_span. The phases cover spans 0, 1, 2,
// the reset value, the largest span and random spans. They also include
// series restarts and a rewrite of the same span while a window is filling.
// ----------------------------------------------------------------------------
module sliding_window_line_fit_test;
	import swlf_pkg::*;

	localparam int RING_DEPTH    = MAX_WINDOW_DEF;
	localparam int SETTLE_CYCLES = 150;
	localparam int STALL_LIMIT   = 5000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic [SAMPLE_BITS_DEF-1:0] sample;
		logic                       new_series;
	} sample_word_t;

	typedef struct {
		logic [OUT_BITS-1:0] intercept;
		logic [OUT_BITS-1:0] slope;
	} line_fit_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [SPAN_BITS-1:0]  cfg_wdata = SPAN_RESET;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata   = '0;   // sample
	logic                  s_tuser   = 1'b0; // new_series
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [2*OUT_BITS-1:0] m_tdata;          // intercept, slope

	sliding_window_line_fit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	int     span_reg = int'(SPAN_RESET);
	int     hist_ring [RING_DEPTH];
	int     wr_ptr;
	int     fill_cnt;
	longint sum_y;
	longint sum_ty;

	sample_word_t pending_words [$];
	line_fit_t    expected_fits [$];

	int words_sent;
	int fits_checked;
	int mismatches;
	int spans_written;
	int burst_left;
	int gap_left;
	int ready_mode;
	int ready_hold;
	int ready_tick;
	int idle_cycles;
	int ramp_left;
	int ramp_val;
	int ramp_step;

	function automatic void drop_history();
		wr_ptr   = 0;
		fill_cnt = 0;
		sum_y    = 0;
		sum_ty   = 0;
	endfunction

	function automatic logic [OUT_BITS-1:0] div_round_q16(longint num, longint unsigned den);
		longint unsigned neg_mag = 64'd1 << (OUT_BITS - 1);
		longint unsigned pos_max = (64'd1 << (OUT_BITS - 1)) - 1;
		longint unsigned mag;
		longint unsigned q;
		longint unsigned r;
		longint unsigned res;
		logic            neg;
		logic [OUT_BITS-1:0] out;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		r = mag % den;
		if (q >= (64'd1 << (OUT_BITS - FRAC_BITS - 1))) begin
			res = neg_mag;
		end else begin
			res = (q << FRAC_BITS) + (((r << (FRAC_BITS + 1)) + den) / (den << 1));
		end
		if (neg) begin
			if (res > neg_mag) begin
				res = neg_mag;
			end
			res = -res;
		end else if (res > pos_max) begin
			res = pos_max;
		end
		out = res[OUT_BITS-1:0];
		return out;
	endfunction

	function automatic void fit_window_line(sample_word_t word);
		longint          y;
		longint          n;
		longint          rest;
		longint          a_num;
		longint          b_num;
		longint unsigned a_den;
		longint unsigned b_den;
		int              oldest;
		line_fit_t       fit;
		y = longint'($signed(word.sample));
		n = longint'(span_reg) + 1;
		if (word.new_series) begin
			drop_history();
		end
		if (fill_cnt >= n) begin
			oldest = int'((wr_ptr + RING_DEPTH - n) % RING_DEPTH);
			rest   = sum_y - hist_ring[oldest];
			sum_ty = sum_ty - rest + (n - 1) * y;
			sum_y  = rest + y;
		end else begin
			sum_ty = sum_ty + fill_cnt * y;
			sum_y  = sum_y + y;
			fill_cnt++;
		end
		hist_ring[wr_ptr] = int'(y);
		wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		if (fill_cnt < n) begin
			return;
		end
		a_num = 2 * (2 * n - 1) * sum_y - 6 * sum_ty;
		a_den = n * (n + 1);
		fit.intercept = div_round_q16(a_num, a_den);
		if (n == 1) begin
			fit.slope = '0;
		end else begin
			b_num = 6 * (2 * sum_ty - (n - 1) * sum_y);
			b_den = n * (n - 1) * (n + 1);
			fit.slope = div_round_q16(b_num, b_den);
		end
		expected_fits.push_back(fit);
	endfunction

	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				fit_window_line(pending_words.pop_front());
				words_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_words[0].sample;
				s_tuser  <= pending_words[0].new_series;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		line_fit_t head;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_fits.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("unexpected word: intercept %0d slope %0d",
							$signed(m_tdata[OUT_BITS-1:0]),
							$signed(m_tdata[2*OUT_BITS-1:OUT_BITS]));
					end
				end else begin
					head = expected_fits.pop_front();
					fits_checked++;
					if (m_tdata[OUT_BITS-1:0] !== head.intercept ||
					    m_tdata[2*OUT_BITS-1:OUT_BITS] !== head.slope) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("fit %0d: intercept exp %0d got %0d, slope exp %0d got %0d",
								fits_checked, $signed(head.intercept),
								$signed(m_tdata[OUT_BITS-1:0]), $signed(head.slope),
								$signed(m_tdata[2*OUT_BITS-1:OUT_BITS]));
						end
					end
				end
			end
			if (ready_hold == 0) begin
				ready_mode = $urandom_range(0, 4);
				ready_hold = $urandom_range(200, 1500);
			end else begin
				ready_hold--;
			end
			ready_tick++;
			case (ready_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= ($urandom_range(0, 1) != 0);
				end
				2: begin
					m_tready <= ($urandom_range(0, 9) != 0);
				end
				3: begin
					m_tready <= ($urandom_range(0, 4) == 0);
				end
				default: begin
					m_tready <= ((ready_tick % 16) < 11);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no word moved for %0d cycles, %0d fits outstanding",
					idle_cycles, expected_fits.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_word(int sample, bit new_series);
		sample_word_t word;
		word.sample     = sample[15:0];
		word.new_series = new_series;
		pending_words.push_back(word);
	endtask

	task automatic queue_random(int count);
		int kind;
		int sample;
		for (int i = 0; i < count; i++) begin
			if (ramp_left > 0) begin
				ramp_left--;
				ramp_val = ramp_val + ramp_step;
				sample = ramp_val;
			end else begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					sample = $urandom;
				end else if (kind < 6) begin
					sample = $urandom_range(0, 1) ? 32767 : -32768;
				end else if (kind < 8) begin
					sample = int'($urandom_range(0, 64)) - 32;
				end else begin
					ramp_left = $urandom_range(10, 60);
					ramp_step = int'($urandom_range(0, 600)) - 300;
					ramp_val  = int'($urandom_range(0, 20000)) - 10000;
					sample = ramp_val;
				end
			end
			push_word(sample, $urandom_range(0, 99) < 2);
		end
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || expected_fits.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_span(int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[SPAN_BITS-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		span_reg = value;
		drop_history();
		spans_written++;
		@(negedge clk);
	endtask

	initial begin
		drop_history();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		repeat (16) push_word(32767, 1'b0);
		repeat (4) push_word(-32768, 1'b0);
		push_word(-32768, 1'b1);
		push_word(0, 1'b0);
		push_word(-1, 1'b0);
		push_word(1, 1'b0);
		drain();

		write_span(0);
		push_word(32767, 1'b0);
		push_word(-32768, 1'b1);
		push_word(-1, 1'b0);
		queue_random(200);
		drain();

		write_span(1);
		queue_random(200);
		drain();

		write_span(255);
		queue_random(150);
		drain();
		queue_random(170);
		drain();

		write_span(2);
		queue_random(150);
		drain();

		write_span(15);
		queue_random(10);
		drain();
		write_span(15);
		queue_random(150);
		drain();

		write_span($urandom_range(3, 20));
		queue_random(150);
		drain();

		write_span($urandom_range(21, 100));
		queue_random(150);
		drain();

		write_span($urandom_range(101, 254));
		queue_random(150);
		drain();

		$display("%0d sample words sent over %0d span writes, %0d line fits checked",
			words_sent, spans_written, fits_checked);
		$display("spans 0, 1, 2, 15, 255 and random ones; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
